@@ rtl/core/sbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbe_pkg: shared definitions for the stack bytecode execute unit
// Instruction codes, status codes, sizes and the ALU request type.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned LocalSlots = 256;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned SaW        = $clog2(StackDepth);
  localparam int unsigned LaW        = $clog2(LocalSlots);
  // Width of the shift count and the iteration count of the divider.
  localparam int unsigned ShW        = 5;
  localparam int unsigned DivSteps   = 32;

  typedef enum logic [4:0] {
    OP_PUSHC = 5'd0,  OP_STLOC = 5'd1,  OP_LOAD  = 5'd2,  OP_INC   = 5'd3,
    OP_DEC   = 5'd4,  OP_ADD   = 5'd5,  OP_SUB   = 5'd6,  OP_MUL   = 5'd7,
    OP_DIV   = 5'd8,  OP_REM   = 5'd9,  OP_AND   = 5'd10, OP_OR    = 5'd11,
    OP_XOR   = 5'd12, OP_SHL   = 5'd13, OP_SHR   = 5'd14, OP_EQ    = 5'd15,
    OP_NE    = 5'd16, OP_LT    = 5'd17, OP_LE    = 5'd18, OP_GT    = 5'd19,
    OP_GE    = 5'd20, OP_LAND  = 5'd21, OP_LOR   = 5'd22, OP_TRUE  = 5'd23,
    OP_FALSE = 5'd24, OP_I2B   = 5'd25, OP_B2I   = 5'd26, OP_NOT   = 5'd27,
    OP_LOG   = 5'd28, OP_JIF   = 5'd29, OP_JMP   = 5'd30, OP_NOP   = 5'd31
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIV0  = 3'd3,
    ST_LOCAL = 3'd4
  } status_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/sbe_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbe_ram: generic single-port RAM
// One access per cycle: a write also reads the old word; read data is registered.
// ----------------------------------------------------------------------------
module sbe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/sbe_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbe_alu: shared arithmetic unit
// Registered logic, add, subtract, shift and compare ops, a registered multiply, and a
// radix-2 restoring divider that takes one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbe_alu
  import sbe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  output      alu_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIX} state_t;

  state_t      state_r;
  op_t         op_r;
  logic [31:0] res_r;
  logic        done_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic        na_r, nb_r;
  logic [5:0]  cnt_r;
  logic [31:0] mul_r;

  logic [31:0] simple;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic        lt_ab, lt_ba, az, bz;

  assign lt_ab = $signed(req.a) < $signed(req.b);
  assign lt_ba = $signed(req.b) < $signed(req.a);
  assign az    = (req.a == 32'd0);
  assign bz    = (req.b == 32'd0);

  always_comb begin
    simple = 32'd0;
    case (req.op)
      OP_ADD:  simple = req.a + req.b;
      OP_SUB:  simple = req.a - req.b;
      OP_AND:  simple = req.a & req.b;
      OP_OR:   simple = req.a | req.b;
      OP_XOR:  simple = req.a ^ req.b;
      OP_SHL:  simple = req.a << req.b[ShW-1:0];
      OP_SHR:  simple = 32'($signed(req.a) >>> req.b[ShW-1:0]);
      OP_EQ:   simple = {31'd0, req.a == req.b};
      OP_NE:   simple = {31'd0, req.a != req.b};
      OP_LT:   simple = {31'd0, lt_ab};
      OP_LE:   simple = {31'd0, !lt_ba};
      OP_GT:   simple = {31'd0, lt_ba};
      OP_GE:   simple = {31'd0, !lt_ab};
      OP_LAND: simple = {31'd0, !az && !bz};
      OP_LOR:  simple = {31'd0, !az || !bz};
      default: simple = 32'd0;
    endcase
  end

  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            if (req.op == OP_MUL) begin
              mul_r   <= req.a * req.b;
              state_r <= S_MUL;
            end else if (req.op == OP_DIV || req.op == OP_REM) begin
              na_r    <= req.a[31];
              nb_r    <= req.b[31];
              quo_r   <= req.a[31] ? 32'd0 - req.a : req.a;
              dvs_r   <= req.b[31] ? 32'd0 - req.b : req.b;
              rem_r   <= 32'd0;
              cnt_r   <= 6'(DivSteps);
              state_r <= S_DIV;
            end else begin
              res_r  <= simple;
              done_r <= 1'b1;
            end
          end
        end
        S_MUL: begin
          res_r   <= mul_r;
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        S_DIV: begin
          // Shift one dividend bit in, keep the difference when it fits.
          if (!trial[32]) begin
            rem_r <= trial[31:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          if (op_r == OP_REM) begin
            res_r <= na_r ? 32'd0 - rem_r : rem_r;
          end else begin
            res_r <= (na_r != nb_r) ? 32'd0 - quo_r : quo_r;
          end
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule
`default_nettype wire

@@ rtl/core/stack_bytecode_execute_unit_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit_core: stack machine execute unit
// Runs one bytecode instruction per request against an operand stack memory
// and a local-variable memory, and returns one result per request.
// ----------------------------------------------------------------------------
// Steps per request: S_RDB, S_RDA (two-operand ops), S_WAITA, S_EXEC, S_ALU
// (two-operand ops; mul registered, div/rem one quotient bit per cycle), then
// S_PUSH for a push or S_TOP and S_TOPW to read the new top, then S_OUT. A
// fault found at decode or a divide by zero goes to S_TOP. The next request
// is taken once S_OUT sees no out_stall. After reset a clearing pass zeroes all
// 256 local slots before the first request; the stack pointer resets to zero.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_unit_core
  import sbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [4:0]  in_operation,
  input  wire logic [15:0] in_operand,
  input  wire logic [31:0] in_constant_value,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  out_status,
  output      logic        out_jump_taken,
  output      logic [15:0] out_jump_target,
  output      logic        out_log_valid,
  output      logic [31:0] out_log_value,
  output      logic [31:0] out_top_value,
  output      logic [6:0]  out_stack_count
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDB, S_RDA, S_WAITA, S_EXEC, S_ALU, S_PUSH, S_TOP, S_TOPW, S_OUT
  } state_t;

  state_t         state_r;
  logic [LaW:0]   clr_r;
  op_t            op_r;
  logic [15:0]    imm_r;
  logic [31:0]    cval_r;
  logic [SpW-1:0] sp_r;
  logic [31:0]    a_r, b_r, r_r, top_r;
  logic [1:0]     need_r;
  logic           push_r;
  logic           out_valid_r;
  status_t        status_r;
  logic           jt_r, lv_r;
  logic [15:0]    jtgt_r;
  logic [31:0]    lval_r;

  // Stack memory port.
  logic            s_we;
  logic [SaW-1:0]  s_addr;
  logic [31:0]     s_wdata, s_rdata;
  // Local memory port.
  logic            l_we;
  logic [LaW-1:0]  l_addr;
  logic [31:0]     l_wdata, l_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [1:0] need_d;
  logic       push_d, uses_local_d;
  op_t        op_d;

  assign op_d = op_t'(in_operation);

  always_comb begin
    need_d = 2'd0;
    if (in_operation inside {[5'd5:5'd22]}) begin
      need_d = 2'd2;
    end else if (in_operation inside {5'd1, [5'd25:5'd29]}) begin
      need_d = 2'd1;
    end
    push_d = in_operation inside {5'd0, 5'd2, [5'd5:5'd27]};
    uses_local_d = in_operation inside {[5'd1:5'd4]};
  end

  sbe_ram #(.Width(32), .Depth(StackDepth)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  sbe_ram #(.Width(32), .Depth(LocalSlots)) u_locals (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
  );

  sbe_alu u_alu (.clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp));

  // Memory and ALU drive, decoded from the sequencer state.
  always_comb begin
    s_we    = 1'b0;
    s_addr  = SaW'(sp_r - SpW'(1));
    s_wdata = r_r;
    l_we    = 1'b0;
    l_addr  = imm_r[LaW-1:0];
    l_wdata = 32'd0;
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    alu_req.a     = a_r;
    alu_req.b     = b_r;
    case (state_r)
      S_CLR: begin
        l_we   = 1'b1;
        l_addr = clr_r[LaW-1:0];
      end
      S_RDA:  s_addr = SaW'(sp_r - SpW'(2));
      S_EXEC: begin
        case (op_r)
          OP_STLOC: begin
            l_we    = 1'b1;
            l_wdata = a_r;
          end
          OP_INC: begin
            l_we    = 1'b1;
            l_wdata = l_rdata + 32'd1;
          end
          OP_DEC: begin
            l_we    = 1'b1;
            l_wdata = l_rdata - 32'd1;
          end
          default: ;
        endcase
        alu_req.start = (need_r == 2'd2);
      end
      S_PUSH: begin
        s_we   = 1'b1;
        s_addr = sp_r[SaW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (LaW+1)'(LocalSlots - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= op_d;
            imm_r    <= in_operand;
            cval_r   <= in_constant_value;
            need_r   <= need_d;
            push_r   <= push_d;
            jt_r     <= 1'b0;
            jtgt_r   <= 16'd0;
            lv_r     <= 1'b0;
            lval_r   <= 32'd0;
            status_r <= ST_OK;
            if (sp_r < SpW'(need_d)) begin
              status_r <= ST_UNDER;
              state_r  <= S_TOP;
            end else if (sp_r - SpW'(need_d) + SpW'(push_d) > SpW'(StackDepth)) begin
              status_r <= ST_OVER;
              state_r  <= S_TOP;
            end else if (uses_local_d && in_operand >= 16'(LocalSlots)) begin
              status_r <= ST_LOCAL;
              state_r  <= S_TOP;
            end else begin
              state_r <= S_RDB;
            end
          end
        end
        S_RDB: begin
          // Top-of-stack read (or local read) issued this cycle.
          state_r <= (need_r == 2'd2) ? S_RDA : S_WAITA;
        end
        S_RDA: begin
          b_r     <= s_rdata;
          state_r <= S_WAITA;
        end
        S_WAITA: begin
          if (need_r == 2'd2) begin
            a_r <= s_rdata;
          end else begin
            a_r <= s_rdata;
          end
          if ((op_r == OP_DIV || op_r == OP_REM) && b_r == 32'd0) begin
            status_r <= ST_DIV0;
            state_r  <= S_TOP;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          sp_r <= sp_r - SpW'(need_r);
          case (op_r)
            OP_PUSHC: r_r <= cval_r;
            OP_LOAD:  r_r <= l_rdata;
            OP_TRUE:  r_r <= 32'd1;
            OP_FALSE: r_r <= 32'd0;
            OP_I2B, OP_B2I: r_r <= {31'd0, a_r != 32'd0};
            OP_NOT:   r_r <= {31'd0, a_r == 32'd0};
            OP_LOG: begin
              lv_r   <= 1'b1;
              lval_r <= a_r;
            end
            OP_JIF: begin
              if (a_r == 32'd0) begin
                jt_r   <= 1'b1;
                jtgt_r <= imm_r;
              end
            end
            OP_JMP: begin
              jt_r   <= 1'b1;
              jtgt_r <= imm_r;
            end
            default: ;
          endcase
          if (need_r == 2'd2) begin
            state_r <= S_ALU;
          end else if (push_r) begin
            state_r <= S_PUSH;
          end else begin
            state_r <= S_TOP;
          end
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            r_r     <= alu_rsp.result;
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          sp_r    <= sp_r + SpW'(1);
          top_r   <= r_r;
          state_r <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_TOP: begin
          // Read the new top through the registered port.
          state_r <= S_TOPW;
        end
        S_TOPW: begin
          top_r       <= (sp_r == '0) ? 32'd0 : s_rdata;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_jump_taken  = jt_r;
  assign out_jump_target = jtgt_r;
  assign out_log_valid   = lv_r;
  assign out_log_value   = lval_r;
  assign out_top_value   = top_r;
  assign out_stack_count = 7'(sp_r);

endmodule
`default_nettype wire
